/* rtl/core/teq_pkg.sv */
package teq_pkg;

	localparam int TIME_W = 31;
	localparam int TAG_W  = 16;
	localparam int TYPE_W = 4;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	typedef enum logic [0:0] {
		KIND_SCHEDULE = 1'b0,
		KIND_PROCESS  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		STAT_SCHEDULED = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_FIRED     = 2'd2,
		STAT_NONE_DUE  = 2'd3
	} status_t;

	// one queue entry as it sits in the memory
	typedef struct packed {
		logic [TIME_W-1:0] due;
		logic [TAG_W-1:0]  tag;
		logic [TYPE_W-1:0] etype;
	} entry_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_S_CMP = 6'b000010,
		ST_S_INS = 6'b000100,
		ST_P_RD  = 6'b001000,
		ST_P_EV  = 6'b010000,
		ST_P_FIN = 6'b100000
	} state_t;

endpackage

/* rtl/core/teq_cmd_if.sv */
interface teq_cmd_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [teq_pkg::TIME_W-1:0]  event_time;
	logic [19:0]                 delay_minutes;
	logic [teq_pkg::TAG_W-1:0]   event_tag;
	logic [teq_pkg::TYPE_W-1:0]  event_type;

	modport source (
		output valid, kind, event_time, delay_minutes, event_tag, event_type,
		input  ready
	);
	modport sink (
		input  valid, kind, event_time, delay_minutes, event_tag, event_type,
		output ready
	);
endinterface

/* rtl/core/teq_rsp_if.sv */
interface teq_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [teq_pkg::TAG_W-1:0]   fired_tag;
	logic [teq_pkg::TYPE_W-1:0]  fired_type;
	logic [teq_pkg::TIME_W-1:0]  due_time;
	logic                        last;

	modport source (
		output valid, status, fired_tag, fired_type, due_time, last,
		input  ready
	);
	modport sink (
		input  valid, status, fired_tag, fired_type, due_time, last,
		output ready
	);
endinterface

/* rtl/core/teq_ram.sv */
module teq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/timed_event_queue.sv */
// Sorted queue of timed events held in one circular memory (head pointer plus
// fill count). A schedule transaction moves each stored event due later than
// the new one up one slot, one entry at a time through the single read and
// write port of the memory, and then writes the new entry into the gap.
// A process transaction on an empty queue, or with nothing due, gives one
// NONE_DUE result; otherwise due events are read from the head, each one
// paced by the memory read and the one-deep result register, and they leave
// by advancing the head, with no copying.
// A new transaction is taken only when the previous one is finished and its
// last result has been taken. No clearing pass is needed after reset.
module timed_event_queue #(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	teq_cmd_if.sink    cmd,
	teq_rsp_if.source  rsp
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	teq_pkg::state_t state_q;
	logic [AW-1:0]   head_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   idx_q;
	logic            pend_q;
	teq_pkg::entry_t pend_entry_q;
	teq_pkg::entry_t new_entry_q;
	logic [teq_pkg::TIME_W-1:0] now_q;

	logic                       rsp_valid_q;
	teq_pkg::status_t           rsp_status_q;
	logic [teq_pkg::TAG_W-1:0]  rsp_tag_q;
	logic [teq_pkg::TYPE_W-1:0] rsp_type_q;
	logic [teq_pkg::TIME_W-1:0] rsp_due_q;
	logic                       rsp_last_q;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	teq_pkg::entry_t ram_wdata;
	logic [AW-1:0]   ram_raddr;
	teq_pkg::entry_t ram_rdata;

	logic                       cmd_take;
	logic [31:0]                sum;
	logic [teq_pkg::TIME_W-1:0] due_in;
	logic                       full;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
	                                       input logic [CW-1:0] idx);
		logic [CW:0] s;
		s = (CW+1)'(head) + (CW+1)'(idx);
		if (s >= (CW+1)'(QUEUE_DEPTH)) begin
			s = s - (CW+1)'(QUEUE_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	teq_ram #(
		.WIDTH ($bits(teq_pkg::entry_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cmd.ready = (state_q == teq_pkg::ST_IDLE) && !rsp_valid_q;
	assign cmd_take  = cmd.valid && cmd.ready;

	// saturating due minute
	assign sum    = {1'b0, cmd.event_time} + {12'd0, cmd.delay_minutes};
	assign due_in = sum[31] ? teq_pkg::TIME_MAX : sum[teq_pkg::TIME_W-1:0];
	assign full   = (count_q == CW'(QUEUE_DEPTH));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = phys(head_q, idx_q);
		ram_wdata = new_entry_q;
		ram_raddr = phys(head_q, idx_q);
		case (state_q)
			teq_pkg::ST_IDLE: begin
				if (cmd.kind == teq_pkg::KIND_SCHEDULE) begin
					ram_raddr = phys(head_q, count_q - CW'(1));
				end else begin
					ram_raddr = head_q;
				end
			end
			teq_pkg::ST_S_CMP: begin
				ram_we = 1'b1;
				if (ram_rdata.due > new_entry_q.due) begin
					// later entry moves up one slot
					ram_wdata = ram_rdata;
					ram_raddr = phys(head_q, idx_q - CW'(2));
				end
			end
			teq_pkg::ST_S_INS: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= teq_pkg::ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				teq_pkg::ST_IDLE: begin
					if (cmd_take) begin
						if (cmd.kind == teq_pkg::KIND_SCHEDULE) begin
							if (full) begin
								rsp_valid_q <= 1'b1;
							end else begin
								idx_q   <= count_q;
								state_q <= (count_q == '0) ? teq_pkg::ST_S_INS
								                           : teq_pkg::ST_S_CMP;
							end
						end else begin
							idx_q  <= '0;
							pend_q <= 1'b0;
							if (count_q == '0) begin
								rsp_valid_q <= 1'b1;
							end else begin
								state_q <= teq_pkg::ST_P_EV;
							end
						end
					end
				end
				teq_pkg::ST_S_CMP: begin
					if (ram_rdata.due > new_entry_q.due) begin
						idx_q <= idx_q - CW'(1);
						if (idx_q == CW'(1)) begin
							state_q <= teq_pkg::ST_S_INS;
						end
					end else begin
						count_q     <= count_q + CW'(1);
						rsp_valid_q <= 1'b1;
						state_q     <= teq_pkg::ST_IDLE;
					end
				end
				teq_pkg::ST_S_INS: begin
					count_q     <= count_q + CW'(1);
					rsp_valid_q <= 1'b1;
					state_q     <= teq_pkg::ST_IDLE;
				end
				teq_pkg::ST_P_RD: begin
					if (!rsp_valid_q) begin
						state_q <= teq_pkg::ST_P_EV;
					end
				end
				teq_pkg::ST_P_EV: begin
					if (ram_rdata.due <= now_q) begin
						// previous due event is not the last one
						if (pend_q) begin
							rsp_valid_q <= 1'b1;
						end
						pend_q <= 1'b1;
						idx_q  <= idx_q + CW'(1);
						state_q <= ((idx_q + CW'(1)) < count_q) ? teq_pkg::ST_P_RD
						                                        : teq_pkg::ST_P_FIN;
					end else begin
						state_q <= teq_pkg::ST_P_FIN;
					end
				end
				teq_pkg::ST_P_FIN: begin
					if (!rsp_valid_q) begin
						rsp_valid_q <= 1'b1;
						head_q      <= phys(head_q, idx_q);
						count_q     <= count_q - idx_q;
						state_q     <= teq_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= teq_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			teq_pkg::ST_IDLE: begin
				if (cmd_take) begin
					new_entry_q.due   <= due_in;
					new_entry_q.tag   <= cmd.event_tag;
					new_entry_q.etype <= cmd.event_type;
					now_q             <= cmd.event_time;
					rsp_tag_q         <= '0;
					rsp_type_q        <= '0;
					rsp_last_q        <= 1'b1;
					if (cmd.kind == teq_pkg::KIND_SCHEDULE) begin
						rsp_status_q <= full ? teq_pkg::STAT_FULL : teq_pkg::STAT_SCHEDULED;
						rsp_due_q    <= due_in;
					end else begin
						rsp_status_q <= teq_pkg::STAT_NONE_DUE;
						rsp_due_q    <= '0;
					end
				end
			end
			teq_pkg::ST_P_EV: begin
				if (ram_rdata.due <= now_q) begin
					pend_entry_q <= ram_rdata;
					if (pend_q) begin
						rsp_status_q <= teq_pkg::STAT_FIRED;
						rsp_tag_q    <= pend_entry_q.tag;
						rsp_type_q   <= pend_entry_q.etype;
						rsp_due_q    <= pend_entry_q.due;
						rsp_last_q   <= 1'b0;
					end
				end
			end
			teq_pkg::ST_P_FIN: begin
				if (!rsp_valid_q) begin
					rsp_last_q <= 1'b1;
					if (pend_q) begin
						rsp_status_q <= teq_pkg::STAT_FIRED;
						rsp_tag_q    <= pend_entry_q.tag;
						rsp_type_q   <= pend_entry_q.etype;
						rsp_due_q    <= pend_entry_q.due;
					end else begin
						rsp_status_q <= teq_pkg::STAT_NONE_DUE;
						rsp_tag_q    <= '0;
						rsp_type_q   <= '0;
						rsp_due_q    <= '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.fired_tag  = rsp_tag_q;
	assign rsp.fired_type = rsp_type_q;
	assign rsp.due_time   = rsp_due_q;
	assign rsp.last       = rsp_last_q;

endmodule
